/* rtl/core/podp_pkg.sv */
package podp_pkg;

	// default sizing
	localparam int DEF_NUM_PORTS   = 16;
	localparam int DEF_COUNT_WIDTH = 16;
	localparam int DEF_NUM_LEVELS  = 3;
	localparam int MAX_LEVELS      = 3;

	// field and bus widths
	localparam int THR_W   = 16;
	localparam int PROB_W  = 17;
	localparam int CNT_O_W = 16;
	localparam int IN_W    = 8;
	localparam int OUT_W   = 40;
	localparam int CFG_AW  = 5;
	localparam int CFG_DW  = 32;

	localparam logic [PROB_W-1:0] PROB_CERTAIN = 17'h10000;
	localparam logic [THR_W-1:0]  ABS_THR_RST  = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_QUERY  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2
	} act_t;

	typedef enum logic [2:0] {
		REG_ABS_THR   = 3'd0,
		REG_L0_LIMIT  = 3'd1,
		REG_L0_PROB   = 3'd2,
		REG_L1_LIMIT  = 3'd3,
		REG_L1_PROB   = 3'd4,
		REG_L2_LIMIT  = 3'd5,
		REG_L2_PROB   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]                  abs_thr;
		logic [MAX_LEVELS-1:0][THR_W-1:0]  limit;
		logic [MAX_LEVELS-1:0][THR_W-1:0]  prob;
	} cfg_t;

	typedef struct packed {
		logic s1_vld;
		logic s2_vld;
	} pipe_st_t;

endpackage

/* rtl/core/port_occupancy_step_drop_probability_unit.sv */
// Channel   Direction  Signals                        Word
// s_*       in         s_tvalid s_tready s_tdata[7:0]  action, port_index
// m_*       out        m_tvalid m_tready m_tdata[39:0] port_count, drop_prob
// APB       in/out     psel penable pwrite paddr ...   threshold registers
//
// Sustained rate one word per cycle while the output is not held. The counter store
// is read in the accept cycle, modified and written back from the read stage with
// forwarding to a following word; update stage and output register carry the result.
// Reset clears the per-port filled bits; unwritten ports read as zero, so
// there is no clearing pass and words are taken straight after reset.
// While an output word waits with m_tready low, the whole pipe holds.
module port_occupancy_step_drop_probability_unit #(
	parameter int NUM_PORTS   = podp_pkg::DEF_NUM_PORTS,
	parameter int COUNT_WIDTH = podp_pkg::DEF_COUNT_WIDTH,
	parameter int NUM_LEVELS  = podp_pkg::DEF_NUM_LEVELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [podp_pkg::IN_W-1:0]   s_tdata,   // [1:0] action, [5:2] port_index
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [podp_pkg::OUT_W-1:0]  m_tdata,   // [15:0] port_count, [32:16] drop_prob
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [podp_pkg::CFG_AW-1:0] paddr,
	input  logic [podp_pkg::CFG_DW-1:0] pwdata,
	output logic [podp_pkg::CFG_DW-1:0] prdata,
	output logic                        pready
);
	import podp_pkg::*;

	cfg_t                   cfg;
	pipe_st_t               st;
	logic                   adv;
	logic                   acc;
	logic [COUNT_WIDTH-1:0] cnt_s2;
	logic [31:0]            cnt_x;
	logic [PROB_W-1:0]      prob;

	logic                   m_tvalid_q;
	logic [CNT_O_W-1:0]     pc_q;
	logic [PROB_W-1:0]      prob_q;

	// pipe moves whenever the output register is free or being emptied
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	podp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	podp_cnt #(
		.NUM_PORTS   (NUM_PORTS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_cnt (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.acc        (acc),
		.act        (s_tdata[1:0]),
		.port_index (s_tdata[5:2]),
		.cnt_s2     (cnt_s2),
		.st         (st)
	);

	podp_prob #(
		.NUM_LEVELS  (NUM_LEVELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_prob (
		.cnt  (cnt_s2),
		.cfg  (cfg),
		.prob (prob)
	);

	// reported count is the low 16 bits of the counter
	assign cnt_x = 32'(cnt_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= st.s2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pc_q   <= cnt_x[CNT_O_W-1:0];
			prob_q <= prob;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - PROB_W - CNT_O_W){1'b0}}, prob_q, pc_q};

`ifndef SYNTHESIS
	a_prob_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> prob_q <= PROB_CERTAIN)
		else $error("drop probability above certain");

	a_acc_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> st.s1_vld)
		else $error("accepted word missing from read stage");

	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st.s2_vld |=> m_tvalid_q)
		else $error("updated count lost before output register");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cnt_s2) && $stable(st))
		else $error("pipe moved during output stall");
`endif

endmodule

/* rtl/core/podp_cfg.sv */
module podp_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [podp_pkg::CFG_AW-1:0] paddr,
	input  logic [podp_pkg::CFG_DW-1:0] pwdata,
	output logic [podp_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	output podp_pkg::cfg_t              cfg
);
	import podp_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.abs_thr <= ABS_THR_RST;
			cfg_q.limit   <= '0;
			cfg_q.prob    <= '0;
		end else if (wr) begin
			case (idx)
				REG_ABS_THR:  cfg_q.abs_thr  <= pwdata[THR_W-1:0];
				REG_L0_LIMIT: cfg_q.limit[0] <= pwdata[THR_W-1:0];
				REG_L0_PROB:  cfg_q.prob[0]  <= pwdata[THR_W-1:0];
				REG_L1_LIMIT: cfg_q.limit[1] <= pwdata[THR_W-1:0];
				REG_L1_PROB:  cfg_q.prob[1]  <= pwdata[THR_W-1:0];
				REG_L2_LIMIT: cfg_q.limit[2] <= pwdata[THR_W-1:0];
				REG_L2_PROB:  cfg_q.prob[2]  <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ABS_THR:  prdata = CFG_DW'(cfg_q.abs_thr);
			REG_L0_LIMIT: prdata = CFG_DW'(cfg_q.limit[0]);
			REG_L0_PROB:  prdata = CFG_DW'(cfg_q.prob[0]);
			REG_L1_LIMIT: prdata = CFG_DW'(cfg_q.limit[1]);
			REG_L1_PROB:  prdata = CFG_DW'(cfg_q.prob[1]);
			REG_L2_LIMIT: prdata = CFG_DW'(cfg_q.limit[2]);
			REG_L2_PROB:  prdata = CFG_DW'(cfg_q.prob[2]);
			default:      prdata = '0;
		endcase
	end

endmodule

/* rtl/core/podp_cnt.sv */
module podp_cnt #(
	parameter int NUM_PORTS   = podp_pkg::DEF_NUM_PORTS,
	parameter int COUNT_WIDTH = podp_pkg::DEF_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   acc,
	input  logic [1:0]             act,
	input  logic [3:0]             port_index,
	output logic [COUNT_WIDTH-1:0] cnt_s2,
	output podp_pkg::pipe_st_t     st
);
	import podp_pkg::*;

	localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	logic [COUNT_WIDTH-1:0] mem [NUM_PORTS];
	logic [NUM_PORTS-1:0]   filled_q;

	logic                   port_ok;
	logic [AW-1:0]          addr;

	logic                   vld_s1;
	logic                   ok_s1;
	logic                   hit_s1;
	logic [1:0]             act_s1;
	logic [AW-1:0]          addr_s1;
	logic [COUNT_WIDTH-1:0] rd_s1;
	logic                   vld_s2;

	logic                   wr_vld_q;
	logic [AW-1:0]          wr_addr_q;
	logic [COUNT_WIDTH-1:0] wr_data_q;

	logic [COUNT_WIDTH-1:0] cnt_old;
	logic [COUNT_WIDTH-1:0] cnt_new;
	logic                   wr_en;

	assign addr    = AW'(port_index);
	assign port_ok = 32'(port_index) < NUM_PORTS;
	assign wr_en   = adv && vld_s1 && ok_s1;
	assign st      = '{s1_vld: vld_s1, s2_vld: vld_s2};

	// counter store: one read port, one write port, registered read
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= mem[addr];
		end
		if (wr_en) begin
			mem[addr_s1] <= cnt_new;
		end
	end

	// write-back of the previous word lands on the same edge as this read
	always_comb begin
		if (wr_vld_q && wr_addr_q == addr_s1) begin
			cnt_old = wr_data_q;
		end else if (hit_s1) begin
			cnt_old = rd_s1;
		end else begin
			cnt_old = '0;
		end
		case (act_s1)
			ACT_INSERT: cnt_new = (cnt_old == '1) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
			ACT_REMOVE: cnt_new = (cnt_old == '0) ? cnt_old : cnt_old - COUNT_WIDTH'(1);
			default:    cnt_new = cnt_old;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			wr_vld_q <= 1'b0;
			filled_q <= '0;
		end else if (adv) begin
			vld_s1   <= acc;
			vld_s2   <= vld_s1;
			wr_vld_q <= wr_en;
			if (wr_en) begin
				filled_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			act_s1  <= act;
			addr_s1 <= addr;
			ok_s1   <= port_ok;
			hit_s1  <= port_ok && filled_q[addr];
		end
		if (adv) begin
			cnt_s2    <= ok_s1 ? cnt_new : '0;
			wr_addr_q <= addr_s1;
			wr_data_q <= cnt_new;
		end
	end

endmodule

/* rtl/core/podp_prob.sv */
module podp_prob #(
	parameter int NUM_LEVELS  = podp_pkg::DEF_NUM_LEVELS,
	parameter int COUNT_WIDTH = podp_pkg::DEF_COUNT_WIDTH
) (
	input  logic [COUNT_WIDTH-1:0]      cnt,
	input  podp_pkg::cfg_t              cfg,
	output logic [podp_pkg::PROB_W-1:0] prob
);
	import podp_pkg::*;

	logic [31:0]      cnt_x;
	logic [THR_W-1:0] best;

	// certain from abs_thr up, else highest enabled step at or below the count; lower level wins a tie
	always_comb begin
		cnt_x = 32'(cnt);
		best  = '0;
		prob  = '0;
		if (cnt_x >= 32'(cfg.abs_thr)) begin
			prob = PROB_CERTAIN;
		end else begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				if (cfg.limit[i] != '0 && cnt_x >= 32'(cfg.limit[i]) && cfg.limit[i] > best) begin
					best = cfg.limit[i];
					prob = PROB_W'(cfg.prob[i]);
				end
			end
		end
	end

endmodule

/* dv/tb_port_occupancy_step_drop_probability_unit.sv */
module tb_port_occupancy_step_drop_probability_unit;
	import podp_pkg::*;

	localparam int          NUM_PORTS   = DEF_NUM_PORTS;
	localparam int          NUM_LEVELS  = DEF_NUM_LEVELS;
	localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
	localparam logic [1:0]  ACT_SPARE   = 2'd3;   // unassigned code, behaves as a query
	localparam logic [2:0]  REG_SPARE   = 3'd7;   // no register behind this index
	localparam int          HOLD_CYCLES = 300;
	localparam int          CYCLE_LIMIT = 600000;

	// input word, packs straight onto s_tdata[5:0]
	typedef struct packed {
		logic [3:0] port;
		logic [1:0] action;
	} occ_word_t;

	typedef struct packed {
		logic [15:0] count;
		logic [16:0] prob;
	} occ_result_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;   // [1:0] action, [5:2] port_index
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;         // [15:0] port_count, [32:16] drop_prob
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [CFG_AW-1:0]   paddr    = '0;
	logic [CFG_DW-1:0]   pwdata   = '0;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;

	port_occupancy_step_drop_probability_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// shadow of the block: per-port counts and threshold registers
	logic [15:0] port_occ  [NUM_PORTS];
	logic [15:0] cfg_abs = ABS_THR_RST;
	logic [15:0] cfg_limit [MAX_LEVELS];
	logic [15:0] cfg_prob  [MAX_LEVELS];

	occ_word_t   offered_words[$];    // words waiting to go out on s_*
	occ_result_t pending_results[$];  // predicted words not yet seen on m_*
	occ_result_t rx_want;

	int  errors       = 0;
	int  cycles       = 0;
	int  words_sent   = 0;
	int  results_seen = 0;
	int  reg_writes   = 0;
	int  tx_gap       = 0;
	int  rx_wait      = 0;
	int  hold_cnt     = 0;
	logic hold_go     = 1'b0;
	bit  tx_idle_on   = 1'b1;
	bit  rx_idle_on   = 1'b1;

	initial begin
		for (int i = 0; i < NUM_PORTS; i++)
			port_occ[i] = '0;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			cfg_limit[i] = '0;
			cfg_prob[i]  = '0;
		end
	end

	initial begin
		forever #5 clk = ~clk;
	end

	// stepped probability: certain at the absolute threshold, else the highest
	// enabled step at or below the count, first listed wins a tie
	function automatic logic [16:0] drop_prob_for(input logic [15:0] n);
		logic [16:0] p;
		logic [15:0] best;
		p    = '0;
		best = '0;
		if (n >= cfg_abs)
			return PROB_CERTAIN;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (cfg_limit[i] != 0 && n >= cfg_limit[i] && cfg_limit[i] > best) begin
				best = cfg_limit[i];
				p    = {1'b0, cfg_prob[i]};
			end
		end
		return p;
	endfunction

	// apply one accepted word to the shadow counts and queue its result
	function automatic void track_word(input occ_word_t w);
		logic [15:0] n;
		occ_result_t r;
		n = port_occ[w.port];
		case (w.action)
			ACT_INSERT: if (n != COUNT_MAX) n = n + 16'd1;
			ACT_REMOVE: if (n != 0) n = n - 16'd1;
			default: ;  // query and the spare code leave the count alone
		endcase
		port_occ[w.port] = n;
		r.count = n;
		r.prob  = drop_prob_for(n);
		pending_results.insert(pending_results.size(), r);
	endfunction

	task automatic note_mismatch(input string what, input logic [16:0] got,
			input logic [16:0] want);
		$display("mismatch on %s: got %0d, expected %0d (result %0d, cycle %0d)",
			what, got, want, results_seen, cycles);
		errors++;
	endtask

	// sender: the front word stays on the bus until taken, then a fresh gap is drawn
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				track_word(offered_words.pop_front());
				words_sent++;
				tx_gap = tx_idle_on ? $urandom_range(0, 16) : 0;
			end
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
				s_tdata  <= IN_W'($urandom);   // junk while idle
			end else if (offered_words.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {2'b00, offered_words[0]};
			end else begin
				s_tvalid <= 1'b0;
				s_tdata  <= IN_W'($urandom);
			end
		end
	end

	// receiver: compare each word against the oldest prediction, then draw a stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					note_mismatch("word with nothing pending", {1'b0, m_tdata[15:0]}, '0);
				end else begin
					rx_want = pending_results.pop_front();
					if (m_tdata[15:0] !== rx_want.count)
						note_mismatch("port_count", {1'b0, m_tdata[15:0]}, {1'b0, rx_want.count});
					if (m_tdata[32:16] !== rx_want.prob)
						note_mismatch("drop_prob", m_tdata[32:16], rx_want.prob);
				end
				rx_wait = rx_idle_on ? $urandom_range(0, 16) : 0;
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0) && (hold_cnt == 0);
		end
	end

	// long output hold-off, so the pipe fills and s_tready drops
	always @(posedge clk) begin
		if (hold_go && hold_cnt == 0)
			hold_cnt <= HOLD_CYCLES;
		else if (hold_cnt != 0)
			hold_cnt <= hold_cnt - 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycles, pending_results.size());
			$display("** port_occupancy_step_drop_probability_unit: FAILED **");
			$finish;
		end
	end

	// APB write: setup, access, register taken at the edge with pready high
	task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_AW'({idx, 2'b00});
		pwdata  <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_ABS_THR:  cfg_abs      = val;
			REG_L0_LIMIT: cfg_limit[0] = val;
			REG_L0_PROB:  cfg_prob[0]  = val;
			REG_L1_LIMIT: cfg_limit[1] = val;
			REG_L1_PROB:  cfg_prob[1]  = val;
			REG_L2_LIMIT: cfg_limit[2] = val;
			REG_L2_PROB:  cfg_prob[2]  = val;
			default: ;  // unmapped index, write dropped
		endcase
		reg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic queue_word(input logic [1:0] act, input logic [3:0] port);
		occ_word_t w;
		w.action = act;
		w.port   = port;
		offered_words.insert(offered_words.size(), w);
	endtask

	// every word gives one result, so an empty prediction queue means idle
	task automatic drain_results();
		while (offered_words.size() != 0 || pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0] cfg_val [7];
		int          ins_pct;
		int          rem_pct;
		int          port_hi;
		int          pick;
		int          base;
		logic [1:0]  act;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: small steps with a tie between levels 1 and 2
		cfg_val = '{16'd5, 16'd2, 16'h4000, 16'd3, 16'hFFFF, 16'd3, 16'h0001};
		for (int r = 0; r < 7; r++)
			reg_write(3'(r), cfg_val[r]);
		reg_write(REG_SPARE, 16'hFFFF);

		queue_word(ACT_QUERY,  4'd0);
		queue_word(ACT_REMOVE, 4'd0);   // removal at zero holds
		queue_word(ACT_SPARE,  4'd0);
		repeat (6) queue_word(ACT_INSERT, 4'd3);   // crosses both steps and abs
		queue_word(ACT_SPARE,  4'd3);
		repeat (7) queue_word(ACT_REMOVE, 4'd3);   // back down to zero, the last removal holds
		queue_word(ACT_INSERT, 4'd15);
		queue_word(ACT_QUERY,  4'd15);
		queue_word(ACT_SPARE,  4'd15);
		queue_word(ACT_REMOVE, 4'd15);
		drain_results();

		// full-scale limits on one port: only the lowest step is reached
		cfg_val = '{16'hFFFF, 16'd60000, 16'h0100, 16'hFFFE, 16'hFFFF, 16'd1, 16'h0002};
		for (int r = 0; r < 7; r++)
			reg_write(3'(r), cfg_val[r]);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (4) queue_word(ACT_INSERT, 4'd9);
		repeat (2) queue_word(ACT_REMOVE, 4'd9);
		queue_word(ACT_INSERT, 4'd9);
		queue_word(ACT_INSERT, 4'd9);
		queue_word(ACT_QUERY,  4'd9);
		drain_results();

		// random phases, each under its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			case (ph)
				0: cfg_val = '{default: 16'h0000};   // abs zero: always certain
				1: cfg_val = '{default: 16'hFFFF};   // all at full scale
				default: begin
					cfg_val[0] = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(4, 40));
					for (int l = 0; l < MAX_LEVELS; l++) begin
						cfg_val[1 + 2*l] = $urandom_range(0, 3) == 0 ? 16'd0
							: 16'($urandom_range(1, 24));
						cfg_val[2 + 2*l] = 16'($urandom);
					end
					if ($urandom_range(0, 2) == 0)
						cfg_val[5] = cfg_val[3];   // tied step limits
				end
			endcase
			for (int r = 0; r < 7; r++)
				reg_write(3'(r), cfg_val[r]);

			tx_idle_on = (ph == 3) ? 1'b0 : 1'($urandom_range(0, 2) != 0);
			rx_idle_on = (ph == 3) ? 1'b1 : 1'($urandom_range(0, 2) != 0);
			ins_pct = $urandom_range(35, 60);
			rem_pct = $urandom_range(25, 40);
			port_hi = (ph % 2) ? 3 : 15;
			for (int k = 0; k < 190; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < ins_pct)
					act = ACT_INSERT;
				else if (pick < ins_pct + rem_pct)
					act = ACT_REMOVE;
				else
					act = $urandom_range(0, 1) ? ACT_QUERY : ACT_SPARE;
				queue_word(act, 4'($urandom_range(0, port_hi)));
			end

			if (ph == 3) begin
				// sender keeps offering while the receiver holds off
				base = words_sent;
				while (words_sent < base + 10)
					@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
		end
		drain_results();
		repeat (10) @(posedge clk);

		$display("%0d words through the block in %0d cycles, %0d results checked, %0d writes",
			words_sent, cycles, results_seen, reg_writes);
		$display("covered: counts at zero, full-scale and tied or disabled steps, %0d-cycle stall",
			HOLD_CYCLES);
		if (errors == 0) begin
			$display("** port_occupancy_step_drop_probability_unit: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** port_occupancy_step_drop_probability_unit: FAILED **");
		end
		$finish;
	end

endmodule

/* port_occupancy_step_drop_probability_unit.f */
rtl/core/podp_pkg.sv
rtl/core/podp_cfg.sv
rtl/core/podp_cnt.sv
rtl/core/podp_prob.sv
rtl/core/port_occupancy_step_drop_probability_unit.sv
dv/tb_port_occupancy_step_drop_probability_unit.sv
